// ===== rtl/grs_pkg.sv =====
// Shared constants and types for the group reverse stream block.
`timescale 1ns / 1ps
package grs_pkg;

  localparam int MAX_GROUP = 16;
  localparam int IDX_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  // Register byte offsets
  localparam logic [ADDR_W-1:0] REG_GROUP_SIZE = 3'd0;

  // One classified element on its way from front to back
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  idx;
    logic              close;
    logic              last;
  } q_item_t;

  // Clamp the programmed group size into 1..MAX_GROUP
  function automatic logic [CNT_W-1:0] eff_k(input logic [4:0] size);
    logic [CNT_W-1:0] k;
    begin
      if (size == 5'd0) begin
        k = CNT_W'(1);
      end else if (32'(size) > MAX_GROUP) begin
        k = CNT_W'(MAX_GROUP);
      end else begin
        k = CNT_W'(size);
      end
      return k;
    end
  endfunction

endpackage

// ===== rtl/grs_front.sv =====
// Front end: numbers each element inside its group and marks where a group closes.
`timescale 1ns / 1ps
module grs_front
  import grs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   element_value,
  input  logic                 end_of_list,
  input  logic [4:0]           group_size,
  output logic                 q_valid,
  input  logic                 q_ready,
  output q_item_t              q_item
);

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] k;
  logic             close;

  assign k        = eff_k(group_size);
  assign close    = ((fill + CNT_W'(1)) >= k) || end_of_list;
  assign in_ready = q_ready;
  assign q_valid  = in_valid;

  assign q_item.value = element_value;
  assign q_item.idx   = fill[IDX_W-1:0];
  assign q_item.close = close;
  assign q_item.last  = end_of_list;

  always_comb begin
    fill_next = fill;
    if (in_valid && q_ready) begin
      fill_next = close ? '0 : fill + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

// ===== rtl/grs_fifo.sv =====
// Two-entry queue between the front end and the group drain engine.
`timescale 1ns / 1ps
module grs_fifo
  import grs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_valid,
  output logic    wr_ready,
  input  q_item_t wr_item,
  output logic    rd_valid,
  input  logic    rd_ready,
  output q_item_t rd_item
);

  q_item_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/grs_back.sv =====
// Back end: stores a group in a small memory and drains it in reverse order.
`timescale 1ns / 1ps
module grs_back
  import grs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  q_item_t             q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_value,
  output logic                group_done,
  output logic                list_done
);

  typedef enum logic [1:0] {
    ST_COLLECT = 2'b01,
    ST_DRAIN   = 2'b10
  } state_t;

  state_t             state;
  logic [DATA_W-1:0]  mem [MAX_GROUP];
  logic [IDX_W-1:0]   rd_ptr;
  logic               list_last;
  logic               pop;
  logic               issue;

  assign q_ready = (state == ST_COLLECT);
  assign pop     = q_valid && q_ready;
  assign issue   = (state == ST_DRAIN) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      mem[q_item.idx] <= q_item.value;
    end
  end

  // Read port doubles as the output register
  always_ff @(posedge clk) begin
    if (issue) begin
      out_value  <= mem[rd_ptr];
      group_done <= (rd_ptr == '0);
      list_done  <= (rd_ptr == '0) && list_last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_item.close) begin
      list_last <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_COLLECT: begin
          if (pop && q_item.close) begin
            rd_ptr <= q_item.idx;
            state  <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (issue) begin
            if (rd_ptr == '0) begin
              state <= ST_COLLECT;
            end else begin
              rd_ptr <= rd_ptr - IDX_W'(1);
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

endmodule

// ===== rtl/group_reverse_stream.sv =====
// Top level of the group reverse stream: config register, front end, queue, drain engine.
//
//  Channel   Signals                                     Direction
//  input     in_valid/in_ready, element_value, end_of_list  in
//  output    out_valid/out_ready, out_value, group_done,
//            list_done                                   out
//  config    psel, penable, pwrite, paddr, pwdata,
//            prdata, pready                              APB slave
//
// A group of k elements is written into the group memory one transfer per
// cycle while collecting, then read back newest first, one result per cycle
// while the output is not stalled; the single group memory takes no new
// group until the last one has drained. While a group drains, the front end
// keeps taking up to two transfers into its queue. The transfer that closes
// a group passes the queue and the drain state before its first result is registered.
// Reset (synchronous, active high) empties the queue, clears the group
// count and sets group_size to 1; memory contents are not cleared.
// Output stalls hold the drain in place; input stalls do not disturb it.
`timescale 1ns / 1ps
module group_reverse_stream
  import grs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  element_value,
  input  logic                end_of_list,
  // output stream
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_value,
  output logic                group_done,
  output logic                list_done,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [4:0] group_size;
  logic       cfg_wr;
  q_item_t    f_item;
  q_item_t    b_item;
  logic       f_valid;
  logic       f_ready;
  logic       b_valid;
  logic       b_ready;

  // Register decode: only bit 2 selects a register, low bits are byte lanes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_GROUP_SIZE[2]);
  assign prdata = (paddr[2] == REG_GROUP_SIZE[2]) ? {27'd0, group_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= 5'd1;
    end else if (cfg_wr) begin
      group_size <= pwdata[4:0];
    end
  end

  // Classify each transfer against the current group size
  grs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .element_value (element_value),
    .end_of_list   (end_of_list),
    .group_size    (group_size),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_item        (f_item)
  );

  // Decouple intake from the drain
  grs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  // Collect each group, then drain it newest first
  grs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_item     (b_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .group_done (group_done),
    .list_done  (list_done)
  );

endmodule

// ===== rtl/grs_checker.sv =====
// Port-level checks for the group reverse stream, bound to the top level.
`timescale 1ns / 1ps
module grs_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic signed [31:0]  out_value,
  input  logic                group_done,
  input  logic                list_done,
  input  logic                psel,
  input  logic                pwrite,
  input  logic [31:0]         prdata,
  input  logic                pready
);

  // A stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(group_done) && $stable(list_done))
    else $error("output changed while stalled");

  // End of list always closes a burst
  a_list_in_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_done |-> group_done)
    else $error("list_done without group_done");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Register reads never show bits beyond the group size field
  a_prdata_narrow: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite |-> (prdata[31:5] == 27'd0) && pready)
    else $error("register read out of range");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (.*);
